FILE: hw/rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Types and constants shared by the sorted table binary search unit.
// ----------------------------------------------------------------------------
package bss_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 10;
    localparam int PROBE_W = 4;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic    clear;
        logic    append;
        logic    start;
        logic    read;
        logic    probe;
        logic    step;
        logic    load_out;
        t_status emit_status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic active;
        logic hit;
        logic out_busy;
    } t_sts;

endpackage

FILE: hw/rtl/bss_ctrl.sv
// ----------------------------------------------------------------------------
// bss_ctrl
// Controller: decodes input beats and sequences the search probes.
// ----------------------------------------------------------------------------
module bss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_kind,
    output logic          o_ready,
    input  bss_pkg::t_sts i_sts,
    output bss_pkg::t_cmd o_cmd
);
    import bss_pkg::*;

    t_state  r_state, n_state;
    t_status r_emit, n_emit;
    t_kind   w_kind;

    assign w_kind  = t_kind'(i_kind);
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= ST_MISS;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (w_kind)
                        KIND_APPEND: begin
                            if (i_sts.full) begin
                                n_state = S_EMIT;
                                n_emit  = ST_FULL;
                            end
                        end
                        KIND_SEARCH: n_state = S_READ;
                        KIND_CLEAR, KIND_NONE: n_state = S_IDLE;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                if (i_sts.active) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_EMIT;
                    n_emit  = ST_MISS;
                end
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    n_state = S_EMIT;
                    n_emit  = ST_FOUND;
                end else begin
                    n_state = S_READ;
                end
            end
            S_EMIT: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd             = '0;
        o_cmd.emit_status = r_emit;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.clear  = (w_kind == KIND_CLEAR);
                    o_cmd.append = (w_kind == KIND_APPEND) && !i_sts.full;
                    o_cmd.start  = (w_kind == KIND_SEARCH);
                end
            end
            S_READ: o_cmd.read = i_sts.active;
            S_CMP: begin
                o_cmd.probe = 1'b1;
                o_cmd.step  = !i_sts.hit;
            end
            S_EMIT: o_cmd.load_out = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/bss_dp.sv
// ----------------------------------------------------------------------------
// bss_dp
// Datapath: table memory, entry count, search bounds, probe count and the
// result register.
// ----------------------------------------------------------------------------
module bss_dp #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [bss_pkg::VALUE_W-1:0] i_value,
    input  bss_pkg::t_cmd                i_cmd,
    output bss_pkg::t_sts                o_sts,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [bss_pkg::POS_W-1:0]    o_position,
    output logic [bss_pkg::PROBE_W-1:0]  o_probes
);
    import bss_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = $clog2(IW + 2);

    logic signed [VALUE_W-1:0] r_mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;
    logic signed [VALUE_W-1:0] r_key;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             r_lo;
    logic [CW-1:0]             r_hi;
    logic [IW-1:0]             r_mid;
    logic [PW-1:0]             r_probes;
    logic                      r_out_valid;
    t_status                   r_out_status;
    logic [POS_W-1:0]          r_out_pos;
    logic [PROBE_W-1:0]        r_out_probes;

    logic [CW:0]               w_sum;
    logic [IW-1:0]             w_mid;
    logic                      w_less;
    logic [31:0]               w_pos32;
    logic [31:0]               w_probes32;

    // hi is exclusive, so the midpoint is floor((lo + hi - 1) / 2)
    assign w_sum      = (CW+1)'(r_lo) + (CW+1)'(r_hi) - (CW+1)'(1);
    assign w_mid      = w_sum[IW:1];
    assign w_less     = (r_key < r_rdata);
    assign w_pos32    = 32'(r_mid);
    assign w_probes32 = 32'(r_probes);

    assign o_sts.full     = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.active   = (r_lo < r_hi);
    assign o_sts.hit      = (r_key == r_rdata);
    assign o_sts.out_busy = r_out_valid;

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            r_mem[r_count[IW-1:0]] <= i_value;
        end
        if (i_cmd.read) begin
            r_rdata <= r_mem[w_mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // search bounds and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key    <= i_value;
            r_lo     <= '0;
            r_hi     <= r_count;
            r_probes <= '0;
        end
        if (i_cmd.read) begin
            r_mid <= w_mid;
        end
        if (i_cmd.probe) begin
            r_probes <= r_probes + PW'(1);
        end
        if (i_cmd.step) begin
            if (w_less) begin
                r_hi <= CW'(r_mid);
            end else begin
                r_lo <= CW'(r_mid) + CW'(1);
            end
        end
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.emit_status;
            r_out_pos    <= (i_cmd.emit_status == ST_FOUND) ? w_pos32[POS_W-1:0] : '0;
            r_out_probes <= (i_cmd.emit_status == ST_FULL) ? '0 : w_probes32[PROBE_W-1:0];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_position = r_out_pos;
    assign o_probes   = r_out_probes;

endmodule

FILE: hw/rtl/sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Table of signed 32-bit entries filled by appends, searched by binary search.
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   input    | i_valid o_ready i_kind i_value        | in
//   result   | o_valid i_ready o_status o_position   | out
//            | o_probes                              |
//
// clear and in-capacity append beats are taken in the idle state; an append to a
// full table goes to emitting a full status. each search probe passes through a
// read and a compare state, set by the registered read of the single table port.
// a result sits in the output register while the next beat is taken; a new
// result waits in the controller until that register is free.
// reset empties the table at once; entries beyond the count are never read.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_kind,
    input  logic signed [bss_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_status,
    output logic [bss_pkg::POS_W-1:0]          o_position,
    output logic [bss_pkg::PROBE_W-1:0]        o_probes
);
    import bss_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    bss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bss_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_value    (i_value),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_position (o_position),
        .o_probes   (o_probes)
    );

endmodule
